/* rtl/rrp_pkg.sv */
// ----------------------------------------------------------------------------
// rrp_pkg: shared definitions for the multi-bulk request parser
// Widths, protocol characters, parse phases, error codes and the structs
// that carry parser state and one result word between the modules.
// ----------------------------------------------------------------------------
package rrp_pkg;

  // Widths of the header counters and the decimal accumulator.
  localparam int COUNT_WIDTH  = 10;
  localparam int LENGTH_WIDTH = 20;
  localparam int ACC_WIDTH    = ((LENGTH_WIDTH > COUNT_WIDTH) ? LENGTH_WIDTH : COUNT_WIDTH) + 1;

  // Fixed field widths of the stream words.
  localparam int BYTE_WIDTH      = 8;
  localparam int ARG_INDEX_WIDTH = 10;
  localparam int ERR_WIDTH       = 3;

  // Stream packing.
  localparam int IN_TDATA_WIDTH  = BYTE_WIDTH;
  localparam int IN_TUSER_WIDTH  = 1;
  localparam int OUT_PAYLOAD_BITS = BYTE_WIDTH + ARG_INDEX_WIDTH;
  localparam int OUT_TDATA_WIDTH = ((OUT_PAYLOAD_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_WIDTH   = OUT_TDATA_WIDTH - OUT_PAYLOAD_BITS;
  localparam int OUT_TUSER_WIDTH = 2 + ERR_WIDTH;

  // Configuration port.
  localparam int CFG_ADDR_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 32;

  // Register indexes, taken from address bit 2.
  localparam logic REG_MAX_COUNT  = 1'b0;
  localparam logic REG_MAX_LENGTH = 1'b1;

  // Saturation value of the accumulator: above any register value.
  localparam logic [ACC_WIDTH-1:0] ACC_CAP = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  // Protocol characters.
  localparam logic [BYTE_WIDTH-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_WIDTH-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_WIDTH-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_WIDTH-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_WIDTH-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_WIDTH-1:0] CH_NINE   = 8'h39;

  typedef enum logic [3:0] {
    PH_STAR,
    PH_COUNT,
    PH_COUNT_LF,
    PH_DOLLAR,
    PH_LEN,
    PH_LEN_LF,
    PH_DATA,
    PH_DATA_CR,
    PH_DATA_LF
  } phase_t;

  typedef enum logic [ERR_WIDTH-1:0] {
    ERR_NONE,
    ERR_NO_STAR,
    ERR_BAD_COUNT,
    ERR_NO_DOLLAR,
    ERR_BAD_LEN,
    ERR_BAD_TERM,
    ERR_OVER,
    ERR_ABORT
  } err_t;

  typedef struct packed {
    phase_t                  phase;
    logic [COUNT_WIDTH-1:0]  args_left;
    logic [LENGTH_WIDTH-1:0] bytes_left;
    logic [ACC_WIDTH-1:0]    accum;
    logic                    digit_seen;
    logic [COUNT_WIDTH-1:0]  cur_arg;
  } parse_state_t;

  typedef struct packed {
    logic [BYTE_WIDTH-1:0]      data;
    logic                       byte_valid;
    logic [ARG_INDEX_WIDTH-1:0] arg_index;
    logic                       arg_end;
    logic                       command_end;
    err_t                       error;
  } result_t;

  localparam parse_state_t STATE_CLEAR = '{PH_STAR, '0, '0, '0, 1'b0, '0};

endpackage

/* rtl/rrp_step.sv */
// ----------------------------------------------------------------------------
// rrp_step: one parser step
// Combinational next-state and result logic for one received byte: header
// markers, decimal accumulation with saturation, limit checks, data counting
// and terminator checks.
// ----------------------------------------------------------------------------
module rrp_step (
  input  rrp_pkg::parse_state_t                 state,
  input  logic [rrp_pkg::BYTE_WIDTH-1:0]        in_byte,
  input  logic                                  abort,
  input  logic [rrp_pkg::COUNT_WIDTH-1:0]       max_count,
  input  logic [rrp_pkg::LENGTH_WIDTH-1:0]      max_length,
  output rrp_pkg::parse_state_t                 state_nxt,
  output rrp_pkg::result_t                      result
);
  import rrp_pkg::*;

  logic                   is_digit;
  logic [3:0]             digit;
  logic [ACC_WIDTH+3:0]   acc_times_ten;
  logic [ACC_WIDTH+3:0]   acc_sum;
  logic [ACC_WIDTH-1:0]   acc_sat;
  logic [COUNT_WIDTH-1:0] args_dec;
  logic [LENGTH_WIDTH-1:0] bytes_dec;
  err_t                   err;

  // Decimal digit decode and saturating accumulate (x10 as two shifts).
  assign is_digit      = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign digit         = 4'(in_byte - CH_ZERO);
  assign acc_times_ten = {1'b0, state.accum, 3'b000} + {3'b000, state.accum, 1'b0};
  assign acc_sum       = acc_times_ten + (ACC_WIDTH+4)'(digit);
  assign acc_sat       = (acc_sum > (ACC_WIDTH+4)'(ACC_CAP)) ? ACC_CAP : acc_sum[ACC_WIDTH-1:0];

  assign args_dec  = state.args_left - COUNT_WIDTH'(1);
  assign bytes_dec = state.bytes_left - LENGTH_WIDTH'(1);

  // Phase sequencing for one byte.
  always_comb begin
    state_nxt          = state;
    err                = ERR_NONE;
    result.data        = '0;
    result.byte_valid  = 1'b0;
    result.arg_index   = ARG_INDEX_WIDTH'(state.cur_arg);
    result.arg_end     = 1'b0;
    result.command_end = 1'b0;

    if (abort) begin
      err = ERR_ABORT;
    end else begin
      unique case (state.phase)
        PH_STAR: begin
          if (in_byte == CH_STAR) begin
            state_nxt.phase      = PH_COUNT;
            state_nxt.accum      = '0;
            state_nxt.digit_seen = 1'b0;
          end else begin
            err = ERR_NO_STAR;
          end
        end
        PH_COUNT: begin
          if (is_digit) begin
            state_nxt.accum      = acc_sat;
            state_nxt.digit_seen = 1'b1;
          end else if (in_byte == CH_CR) begin
            if (!state.digit_seen || (state.accum == '0)) begin
              err = ERR_BAD_COUNT;
            end else if (state.accum > ACC_WIDTH'(max_count)) begin
              err = ERR_OVER;
            end else begin
              state_nxt.phase = PH_COUNT_LF;
            end
          end else begin
            err = ERR_BAD_COUNT;
          end
        end
        PH_COUNT_LF: begin
          if (in_byte == CH_LF) begin
            state_nxt.args_left = state.accum[COUNT_WIDTH-1:0];
            state_nxt.cur_arg   = '0;
            state_nxt.phase     = PH_DOLLAR;
          end else begin
            err = ERR_BAD_TERM;
          end
        end
        PH_DOLLAR: begin
          if (in_byte == CH_DOLLAR) begin
            state_nxt.phase      = PH_LEN;
            state_nxt.accum      = '0;
            state_nxt.digit_seen = 1'b0;
          end else begin
            err = ERR_NO_DOLLAR;
          end
        end
        PH_LEN: begin
          if (is_digit) begin
            state_nxt.accum      = acc_sat;
            state_nxt.digit_seen = 1'b1;
          end else if (in_byte == CH_CR) begin
            if (!state.digit_seen) begin
              err = ERR_BAD_LEN;
            end else if (state.accum > ACC_WIDTH'(max_length)) begin
              err = ERR_OVER;
            end else begin
              state_nxt.phase = PH_LEN_LF;
            end
          end else begin
            err = ERR_BAD_LEN;
          end
        end
        PH_LEN_LF: begin
          if (in_byte == CH_LF) begin
            state_nxt.bytes_left = state.accum[LENGTH_WIDTH-1:0];
            // An empty argument goes straight to its terminator.
            state_nxt.phase = (state.accum[LENGTH_WIDTH-1:0] == '0) ? PH_DATA_CR : PH_DATA;
          end else begin
            err = ERR_BAD_TERM;
          end
        end
        PH_DATA: begin
          result.data          = in_byte;
          result.byte_valid    = 1'b1;
          state_nxt.bytes_left = bytes_dec;
          if (bytes_dec == '0) begin
            state_nxt.phase = PH_DATA_CR;
          end
        end
        PH_DATA_CR: begin
          if (in_byte == CH_CR) begin
            state_nxt.phase = PH_DATA_LF;
          end else begin
            err = ERR_BAD_TERM;
          end
        end
        PH_DATA_LF: begin
          if (in_byte == CH_LF) begin
            result.arg_end = 1'b1;
            if (args_dec == '0) begin
              result.command_end = 1'b1;
              state_nxt          = STATE_CLEAR;
            end else begin
              state_nxt.args_left = args_dec;
              state_nxt.cur_arg   = state.cur_arg + COUNT_WIDTH'(1);
              state_nxt.phase     = PH_DOLLAR;
            end
          end else begin
            err = ERR_BAD_TERM;
          end
        end
        default: begin
          state_nxt = STATE_CLEAR;
        end
      endcase
    end

    // Any error drops the partial request.
    if (err != ERR_NONE) begin
      state_nxt = STATE_CLEAR;
    end
    result.error = err;
  end

endmodule

/* rtl/resp_request_parser.sv */
// ----------------------------------------------------------------------------
// resp_request_parser: multi-bulk request parser
// Takes the request byte stream one word per cycle while the result word
// is not stalled, and emits one result word per input word: data bytes
// tagged with their argument index, end flags and a dense error code.
// ----------------------------------------------------------------------------
// Each input word gives exactly one output word, in the cycle after it is
// accepted. The parser takes one word every cycle unless the output word is
// stalled: the whole per-byte state update (phase, decimal accumulate, limit
// compare, counters) is combinational, and the output register takes a new
// word as the old one drains: in_tready drops only when it is stalled.
// There are no memories and no clearing pass; the parser expects '*' right
// after reset. On an error or an abort the word carries a nonzero error code
// and the parser restarts at the next '*'. Limit registers sit at byte
// address 0 (max argument count) and 4 (max argument length), reset to all
// ones, and should be written only while the stream is idle.
module resp_request_parser (
  input  logic                                 clk,
  input  logic                                 rst_n,

  // Input stream.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [rrp_pkg::IN_TDATA_WIDTH-1:0]   in_tdata,   // [7:0] in_byte
  input  logic [rrp_pkg::IN_TUSER_WIDTH-1:0]   in_tuser,   // [0] abort

  // Result stream.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [rrp_pkg::OUT_TDATA_WIDTH-1:0]  out_tdata,  // [7:0] out_byte,
                                                           // [17:8] arg_index, rest 0
  output logic [rrp_pkg::OUT_TUSER_WIDTH-1:0]  out_tuser,  // [0] byte_valid,
                                                           // [1] arg_end, [4:2] error_code
  output logic                                 out_tlast,  // command_end

  // Configuration port.
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [rrp_pkg::CFG_ADDR_WIDTH-1:0]   cfg_paddr,
  input  logic [rrp_pkg::CFG_DATA_WIDTH-1:0]   cfg_pwdata,
  output logic [rrp_pkg::CFG_DATA_WIDTH-1:0]   cfg_prdata,
  output logic                                 cfg_pready
);
  import rrp_pkg::*;

  parse_state_t            state_r;
  parse_state_t            state_nxt;
  result_t                 res_r;
  result_t                 res_nxt;
  logic                    out_valid_r;
  logic [COUNT_WIDTH-1:0]  max_count_r;
  logic [LENGTH_WIDTH-1:0] max_length_r;
  logic                    in_fire;
  logic                    cfg_write;
  logic                    reg_sel;

  // Configuration registers: write on the access phase.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_count_r  <= '1;
      max_length_r <= '1;
    end else if (cfg_write) begin
      if (reg_sel == REG_MAX_COUNT) begin
        max_count_r <= cfg_pwdata[COUNT_WIDTH-1:0];
      end else begin
        max_length_r <= cfg_pwdata[LENGTH_WIDTH-1:0];
      end
    end
  end

  // Register read-back.
  always_comb begin
    if (reg_sel == REG_MAX_COUNT) begin
      cfg_prdata = CFG_DATA_WIDTH'(max_count_r);
    end else begin
      cfg_prdata = CFG_DATA_WIDTH'(max_length_r);
    end
  end

  // Per-byte parser step.
  rrp_step u_step (
    .state      (state_r),
    .in_byte    (in_tdata[BYTE_WIDTH-1:0]),
    .abort      (in_tuser[0]),
    .max_count  (max_count_r),
    .max_length (max_length_r),
    .state_nxt  (state_nxt),
    .result     (res_nxt)
  );

  // Accept whenever the output register is empty or being drained.
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r <= state_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  // Output packing.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_WIDTH{1'b0}}, res_r.arg_index, res_r.data};
  assign out_tuser  = {res_r.error, res_r.arg_end, res_r.byte_valid};
  assign out_tlast  = res_r.command_end;

`ifndef NO_ASSERTIONS
  // The end of a command is always also the end of an argument.
  a_cmd_end_has_arg_end: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> res_r.arg_end
  ) else $error("command_end without arg_end");

  // An errored word carries neither data nor end flags.
  a_error_is_bare: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_tvalid && (res_r.error != ERR_NONE)) |->
      (!res_r.byte_valid && !res_r.arg_end && !res_r.command_end)
  ) else $error("error word carries data or end flags");

  // An error restarts the parser at the star marker.
  a_error_restarts: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_fire && (res_nxt.error != ERR_NONE)) |=>
      ((state_r.phase == PH_STAR) && (state_r.cur_arg == '0))
  ) else $error("parser did not restart after an error");

  // A stalled result word blocks the input side.
  a_stall_blocks_input: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready
  ) else $error("input accepted while result word stalled");

  // Argument data is only produced inside a request.
  a_data_in_request: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_fire && res_nxt.byte_valid) |-> (state_r.args_left != '0)
  ) else $error("data byte outside a request");
`endif

endmodule

/* sim/resp_request_parser_tb.sv */
// ----------------------------------------------------------------------------
// resp_request_parser_tb: self-checking bench for the multi-bulk request parser
// Streams request bytes into the parser and predicts every result word from
// its own copy of the parse state and the limit registers. The run starts
// with directed requests and error cases. It then feeds random requests,
// mostly well formed and some broken, under several limit settings and
// idle patterns, and checks every result word field by field.
// ----------------------------------------------------------------------------
module resp_request_parser_tb;
  import rrp_pkg::*;

  // One input word: a stream byte and its abort flag.
  typedef struct packed {
    logic [BYTE_WIDTH-1:0] value;
    logic                  abort_flag;
  } stream_word_t;

  // Predicts the parser's result words and checks the ones that come back.
  class resp_scoreboard;
    result_t                 expected_words[$];
    int                      failures;
    logic [COUNT_WIDTH-1:0]  max_count;
    logic [LENGTH_WIDTH-1:0] max_length;
    phase_t                  phase;
    logic [COUNT_WIDTH-1:0]  args_left;
    logic [LENGTH_WIDTH-1:0] bytes_left;
    logic [ACC_WIDTH-1:0]    decimal;
    logic                    have_digit;
    logic [COUNT_WIDTH-1:0]  cur_arg;

    function new();
      failures   = 0;
      max_count  = '1;
      max_length = '1;
      clear_parse();
    endfunction

    function void clear_parse();
      phase      = PH_STAR;
      args_left  = '0;
      bytes_left = '0;
      decimal    = '0;
      have_digit = 1'b0;
      cur_arg    = '0;
    endfunction

    function void set_limit(logic reg_sel, logic [CFG_DATA_WIDTH-1:0] value);
      if (reg_sel == REG_MAX_COUNT) begin
        max_count = value[COUNT_WIDTH-1:0];
      end else begin
        max_length = value[LENGTH_WIDTH-1:0];
      end
    endfunction

    // The decimal accumulator saturates just above any limit value.
    function void add_digit(int unsigned digit);
      int unsigned sum;
      sum = 32'(decimal) * 10 + digit;
      decimal = (sum > ACC_CAP) ? ACC_CAP : sum[ACC_WIDTH-1:0];
      have_digit = 1'b1;
    endfunction

    // Works out the result word of one accepted input word.
    function void predict_word(logic [BYTE_WIDTH-1:0] in_byte, logic abort_flag);
      result_t res;
      err_t    fault;
      logic    is_digit;
      res = '0;
      fault = ERR_NONE;
      is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
      res.arg_index = cur_arg;
      if (abort_flag) begin
        fault = ERR_ABORT;
      end else begin
        case (phase)
          PH_STAR: begin
            if (in_byte == CH_STAR) begin
              phase = PH_COUNT;
              decimal = '0;
              have_digit = 1'b0;
            end else begin
              fault = ERR_NO_STAR;
            end
          end
          PH_COUNT: begin
            if (is_digit) begin
              add_digit(in_byte - CH_ZERO);
            end else if (in_byte == CH_CR) begin
              if (!have_digit || decimal == 0) fault = ERR_BAD_COUNT;
              else if (decimal > max_count) fault = ERR_OVER;
              else phase = PH_COUNT_LF;
            end else begin
              fault = ERR_BAD_COUNT;
            end
          end
          PH_COUNT_LF: begin
            if (in_byte == CH_LF) begin
              args_left = decimal[COUNT_WIDTH-1:0];
              cur_arg = '0;
              phase = PH_DOLLAR;
            end else begin
              fault = ERR_BAD_TERM;
            end
          end
          PH_DOLLAR: begin
            if (in_byte == CH_DOLLAR) begin
              phase = PH_LEN;
              decimal = '0;
              have_digit = 1'b0;
            end else begin
              fault = ERR_NO_DOLLAR;
            end
          end
          PH_LEN: begin
            if (is_digit) begin
              add_digit(in_byte - CH_ZERO);
            end else if (in_byte == CH_CR) begin
              if (!have_digit) fault = ERR_BAD_LEN;
              else if (decimal > max_length) fault = ERR_OVER;
              else phase = PH_LEN_LF;
            end else begin
              fault = ERR_BAD_LEN;
            end
          end
          PH_LEN_LF: begin
            if (in_byte == CH_LF) begin
              bytes_left = decimal[LENGTH_WIDTH-1:0];
              phase = (bytes_left == 0) ? PH_DATA_CR : PH_DATA;
            end else begin
              fault = ERR_BAD_TERM;
            end
          end
          PH_DATA: begin
            res.data = in_byte;
            res.byte_valid = 1'b1;
            bytes_left = bytes_left - 1'b1;
            if (bytes_left == 0) phase = PH_DATA_CR;
          end
          PH_DATA_CR: begin
            if (in_byte == CH_CR) phase = PH_DATA_LF;
            else fault = ERR_BAD_TERM;
          end
          PH_DATA_LF: begin
            if (in_byte == CH_LF) begin
              res.arg_end = 1'b1;
              args_left = args_left - 1'b1;
              if (args_left == 0) begin
                res.command_end = 1'b1;
                clear_parse();
              end else begin
                cur_arg = cur_arg + 1'b1;
                phase = PH_DOLLAR;
              end
            end else begin
              fault = ERR_BAD_TERM;
            end
          end
          default: clear_parse();
        endcase
      end
      // Every error drops the partial request and waits for a new star.
      if (fault != ERR_NONE) clear_parse();
      res.error = fault;
      expected_words.push_back(res);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        failures++;
      end
    endfunction

    // Checks one result word against the oldest prediction.
    function void check_word(result_t got);
      result_t want;
      if (expected_words.size() == 0) begin
        $error("result word with no expectation waiting");
        failures++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("out_byte", want.data, got.data);
      compare_field("byte_valid", want.byte_valid, got.byte_valid);
      compare_field("arg_index", want.arg_index, got.arg_index);
      compare_field("arg_end", want.arg_end, got.arg_end);
      compare_field("command_end", want.command_end, got.command_end);
      compare_field("error_code", want.error, got.error);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  logic [IN_TDATA_WIDTH-1:0]   in_tdata = '0;
  logic [IN_TUSER_WIDTH-1:0]   in_tuser = '0;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [OUT_TDATA_WIDTH-1:0]  out_tdata;
  logic [OUT_TUSER_WIDTH-1:0]  out_tuser;
  logic                        out_tlast;
  logic                        cfg_psel = 1'b0;
  logic                        cfg_penable = 1'b0;
  logic                        cfg_pwrite = 1'b0;
  logic [CFG_ADDR_WIDTH-1:0]   cfg_paddr = '0;
  logic [CFG_DATA_WIDTH-1:0]   cfg_pwdata = '0;
  logic [CFG_DATA_WIDTH-1:0]   cfg_prdata;
  logic                        cfg_pready;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  resp_scoreboard sbd = new();

  resp_request_parser u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Clock with a period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Random receiver stalls.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every accepted input word gets its prediction.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sbd.predict_word(in_tdata[BYTE_WIDTH-1:0], in_tuser[0]);
    end
  end

  // Every accepted result word is unpacked and checked.
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.data        = out_tdata[BYTE_WIDTH-1:0];
      got.arg_index   = out_tdata[BYTE_WIDTH +: ARG_INDEX_WIDTH];
      got.byte_valid  = out_tuser[0];
      got.arg_end     = out_tuser[1];
      got.error       = err_t'(out_tuser[2 +: ERR_WIDTH]);
      got.command_end = out_tlast;
      sbd.check_word(got);
    end
  end

  function automatic void put_char(ref stream_word_t q[$], input logic [BYTE_WIDTH-1:0] c,
                                   input logic abort_flag = 1'b0);
    q.push_back('{c, abort_flag});
  endfunction

  // Decimal digits, sometimes with leading zeros.
  function automatic void put_number(ref stream_word_t q[$], input int unsigned value);
    string digits;
    digits = $sformatf("%0d", value);
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(2, 1)) put_char(q, CH_ZERO);
    end
    for (int i = 0; i < digits.len(); i++) put_char(q, digits[i]);
  endfunction

  function automatic void put_header(ref stream_word_t q[$], input logic [BYTE_WIDTH-1:0] marker,
                                     input int unsigned value);
    put_char(q, marker);
    put_number(q, value);
    put_char(q, CH_CR);
    put_char(q, CH_LF);
  endfunction

  // One random request, mostly within the current limits, sometimes broken.
  function automatic void build_request(ref stream_word_t q[$]);
    logic [BYTE_WIDTH-1:0] specials [4] = '{CH_CR, CH_LF, CH_STAR, CH_DOLLAR};
    stream_word_t          req[$];
    stream_word_t          noise;
    int unsigned           count, len, cap, pick, pos;
    cap = (sbd.max_count < 4) ? sbd.max_count : 4;
    if (cap == 0) cap = 1;
    count = $urandom_range(cap, 1);
    pick = $urandom_range(99);
    if (pick < 6) count = sbd.max_count + 1;
    else if (pick < 9) count = 0;
    else if (pick < 11) count = 99999999;
    put_header(req, CH_STAR, count);
    for (int a = 0; a < ((count < 4) ? count : 4); a++) begin
      cap = ($urandom_range(9) == 0) ? 40 : 6;
      if (sbd.max_length < cap) cap = sbd.max_length;
      len = $urandom_range(cap, 0);
      if ($urandom_range(19) == 0) len = sbd.max_length + 1;
      put_header(req, CH_DOLLAR, len);
      for (int k = 0; k < len && k < 40; k++) begin
        put_char(req, ($urandom_range(3) == 0) ? specials[$urandom_range(3)]
                                               : 8'($urandom_range(255)));
      end
      put_char(req, CH_CR);
      put_char(req, CH_LF);
    end
    // Break the request at a random point: replace, abort, drop or insert a word.
    if ($urandom_range(4) == 0) begin
      pos = $urandom_range(req.size() - 1);
      noise = '{8'($urandom_range(255)), 1'b0};
      case ($urandom_range(3))
        0: req[pos] = noise;
        1: req[pos] = '{noise.value, 1'b1};
        2: req.delete(pos);
        default: req.insert(pos, noise);
      endcase
    end
    // Occasional line noise between requests.
    if ($urandom_range(19) == 0) begin
      repeat ($urandom_range(3, 1)) put_char(req, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
    foreach (req[i]) q.push_back(req[i]);
  endfunction

  // Offers one word with random gaps and waits until it is taken.
  task automatic send_word(stream_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w.value;
    in_tuser <= w.abort_flag;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_all(ref stream_word_t q[$]);
    foreach (q[i]) send_word(q[i]);
    q.delete();
  endtask

  // Stops the input and waits until every predicted word has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sbd.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(logic reg_sel, logic [CFG_DATA_WIDTH-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_sel, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sbd.set_limit(reg_sel, value);
  endtask

  // Main stimulus.
  initial begin
    stream_word_t              words[$];
    int unsigned               sent;
    logic [CFG_DATA_WIDTH-1:0] count_limit, length_limit;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 34;
    recv_stall_pct = 62;

    // Directed: smallest request with a 0xFF data byte, abort while idle,
    // a zero byte where a star belongs, a zero count and a saturating count.
    put_header(words, CH_STAR, 1);
    put_header(words, CH_DOLLAR, 1);
    put_char(words, 8'hFF);
    put_char(words, CH_CR);
    put_char(words, CH_LF);
    put_char(words, 8'hFF, 1'b1);
    put_char(words, 8'h00);
    put_char(words, CH_STAR);
    put_char(words, CH_ZERO);
    put_char(words, CH_CR);
    put_char(words, CH_STAR);
    put_number(words, 9999999);
    put_char(words, CH_CR);
    send_all(words);

    // Random requests under several limit settings and idle patterns.
    for (int s = 0; s < 6; s++) begin
      if (s > 0) begin
        drain();
        case (s)
          1: begin count_limit = 1; length_limit = 0; end
          2: begin count_limit = 0; length_limit = 3; end
          3: begin count_limit = 3; length_limit = 16; end
          4: begin count_limit = '1; length_limit = '1; end
          default: begin
            count_limit = $urandom_range(1023, 1);
            length_limit = $urandom_range(1048575, 0);
          end
        endcase
        write_reg(REG_MAX_COUNT, count_limit);
        write_reg(REG_MAX_LENGTH, length_limit);
        cfg_psel <= 1'b0;
        cfg_penable <= 1'b0;
        cfg_pwrite <= 1'b0;
      end
      if (s == 2) begin
        send_idle_pct = 62;
        recv_stall_pct = 34;
      end else if (s == 4) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      sent = 0;
      while (sent < 90) begin
        build_request(words);
        sent += words.size();
        send_all(words);
      end
      // A request with the largest argument count, cut short by an abort.
      if (s == 4) begin
        put_header(words, CH_STAR, 1023);
        for (int a = 0; a < 3; a++) begin
          put_header(words, CH_DOLLAR, 0);
          put_char(words, CH_CR);
          put_char(words, CH_LF);
        end
        put_char(words, CH_DOLLAR, 1'b1);
        send_all(words);
      end
    end

    drain();
    if (sbd.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* resp_request_parser.f */
rtl/rrp_pkg.sv
rtl/rrp_step.sv
rtl/resp_request_parser.sv
sim/resp_request_parser_tb.sv
